// ===== hw/rtl/pit_pkg.sv =====
// ----------------------------------------------------------------------------
// pit_pkg
// Shared constants and tables for the 3D point-in-triangle test pipeline.
// ----------------------------------------------------------------------------
package pit_pkg;

   // default coordinate width (signed Q8.8)
   localparam int COORD_WIDTH_DEF = 16;

   // plane tolerance register
   localparam int             TOL_WIDTH = 52;
   localparam logic [51:0]    TOL_RESET = 52'd167772;

   // configuration port
   localparam int             CSR_DATA_W  = 64;
   localparam int             CSR_ADDR_W  = 4;
   localparam logic           CSR_IDX_TOL = 1'b0;

   // pipeline depth, one valid bit per stage
   localparam int STAGES = 7;

   // difference vectors built in the first stage
   localparam int N_DIFF = 6;
   localparam int V_CB   = 0;   // c - b
   localparam int V_PB   = 1;   // p - b
   localparam int V_AB   = 2;   // a - b
   localparam int V_CA   = 3;   // c - a
   localparam int V_PA   = 4;   // p - a
   localparam int V_BA   = 5;   // b - a

   // cross products: x[k] = diff[CROSS_U[k]] x diff[CROSS_V[k]]
   localparam int N_CROSS = 6;
   localparam int CROSS_U [N_CROSS] = '{V_CB, V_CB, V_CA, V_CA, V_BA, V_BA};
   localparam int CROSS_V [N_CROSS] = '{V_PB, V_AB, V_PA, V_BA, V_PA, V_CA};

   // wide vectors after the cross stage: six crosses plus p - a carried along
   localparam int N_XVEC = 7;
   localparam int X_PA   = 6;
   localparam int X_NORM = 5;   // (b-a) x (c-a), the triangle normal

   // dot products: dot[d] = xvec[DOT_U[d]] . xvec[DOT_V[d]]
   // the first three are the same-side tests, the last the plane distance
   localparam int N_DOT = 4;
   localparam int D_PLANE = 3;
   localparam int DOT_U [N_DOT] = '{0, 2, 4, X_PA};
   localparam int DOT_V [N_DOT] = '{1, 3, 5, X_NORM};

   // cyclic component indexes for cross products
   localparam int NEXT1 [3] = '{1, 2, 0};
   localparam int NEXT2 [3] = '{2, 0, 1};

endpackage

// ===== hw/rtl/point_in_triangle_test_top.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_test_top
// 3D same-side point-in-triangle test with plane distance check.
//
// Each req transaction carries a query point P and triangle vertices A, B, C
// (signed fixed point, COORD_WIDTH bits each). Each yields one rsp
// transaction whose inside_res is 1 when P passes all three same-side tests
// (boundary counts as inside) and |(A-P).((A-B)x(A-C))| <= plane_tolerance.
// All arithmetic is exact at full width.
// Throughput is one transaction per cycle while rsp_stall is low, through the
// seven-stage pipeline (differences, cross products in two stages, dot
// products in three, decision).
// Each stage holds its own valid bit, so bubbles close up when the receiver
// stalls; req_stall rises only once all seven stages hold transactions and
// rsp_stall is high. Nothing is lost or repeated under stall.
// plane_tolerance sits at csr byte address 0 (64-bit data, low 52 bits used)
// and resets to 167772. Reset clears all valid bits; write csr only while idle.
// ----------------------------------------------------------------------------
module point_in_triangle_test_top #(
   parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_WIDTH-1:0]     req_point_x,
   input  logic signed [COORD_WIDTH-1:0]     req_point_y,
   input  logic signed [COORD_WIDTH-1:0]     req_point_z,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_a_x,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_a_y,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_a_z,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_b_x,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_b_y,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_b_z,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_c_x,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_c_y,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_c_z,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_inside_res,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pit_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pit_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pit_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import pit_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int CW = 2 * COORD_WIDTH + 3;
   localparam int SW = 4 * COORD_WIDTH + 8;

   logic [STAGES-1:0]    valid_ff;
   logic [STAGES-1:0]    valid_in;
   logic [STAGES:0]      stage_ready;
   logic [STAGES-1:0]    load_en;
   logic [TOL_WIDTH-1:0] tol_ff;
   logic [TOL_WIDTH-1:0] tol_in;
   logic                 csr_wr_tol;
   logic                 csr_reg_idx;

   logic signed [DW-1:0] diff_vec [N_DIFF][3];
   logic signed [CW-1:0] cross_vec [N_XVEC][3];
   logic signed [SW-1:0] dot_sum [N_DOT];

   // ---------------- configuration ----------------
   assign csr_reg_idx = csr_paddr[3];
   assign csr_pready  = 1'b1;
   assign csr_wr_tol  = csr_psel & csr_penable & csr_pwrite & csr_pready
                      & (csr_reg_idx == CSR_IDX_TOL);
   assign tol_in      = csr_wr_tol ? csr_pwdata[TOL_WIDTH-1:0] : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   always_comb begin
      case (csr_reg_idx)
         CSR_IDX_TOL: csr_prdata = {{(CSR_DATA_W-TOL_WIDTH){1'b0}}, tol_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // a stage loads when it is empty or its occupant moves on
   always_comb begin
      stage_ready[STAGES] = ~rsp_stall;
      for (int k = STAGES - 1; k >= 0; k--) begin
         stage_ready[k] = ~valid_ff[k] | stage_ready[k+1];
      end
      load_en  = stage_ready[STAGES-1:0];
      valid_in = {valid_ff[STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (load_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = ~stage_ready[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // ---------------- datapath ----------------
   pit_diff #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_diff (
      .clock      (clock),
      .load_en    (load_en[0]),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .point_z    (req_point_z),
      .vertex_a_x (req_vertex_a_x),
      .vertex_a_y (req_vertex_a_y),
      .vertex_a_z (req_vertex_a_z),
      .vertex_b_x (req_vertex_b_x),
      .vertex_b_y (req_vertex_b_y),
      .vertex_b_z (req_vertex_b_z),
      .vertex_c_x (req_vertex_c_x),
      .vertex_c_y (req_vertex_c_y),
      .vertex_c_z (req_vertex_c_z),
      .diff_vec   (diff_vec)
   );

   pit_cross #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_cross (
      .clock     (clock),
      .load_en   (load_en[2:1]),
      .diff_vec  (diff_vec),
      .cross_vec (cross_vec)
   );

   pit_dot #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dot (
      .clock     (clock),
      .load_en   (load_en[5:3]),
      .cross_vec (cross_vec),
      .dot_sum   (dot_sum)
   );

   pit_decide #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_decide (
      .clock           (clock),
      .load_en         (load_en[6]),
      .dot_sum         (dot_sum),
      .plane_tolerance (tol_ff),
      .inside_res      (rsp_inside_res)
   );

   // ---------------- assertions ----------------
   // input backs up only when every stage is occupied and the output is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("req_stall with a free pipeline stage");

   // an accepted transaction lands in the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted transaction missing from first stage");

   // a blocked middle stage keeps its transaction
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && !stage_ready[4]) |=> valid_ff[3])
      else $error("blocked stage dropped its transaction");

   // tolerance write takes the low bits of the write data
   a_tol_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_tol |=> (tol_ff == $past(csr_pwdata[TOL_WIDTH-1:0])))
      else $error("plane tolerance write not taken");

endmodule

// ===== hw/rtl/pit_diff.sv =====
// ----------------------------------------------------------------------------
// pit_diff
// Stage 1: edge and point difference vectors, one bit wider than a coordinate.
// ----------------------------------------------------------------------------
module pit_diff #(
   parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          load_en,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic signed [COORD_WIDTH-1:0] point_z,
   input  logic signed [COORD_WIDTH-1:0] vertex_a_x,
   input  logic signed [COORD_WIDTH-1:0] vertex_a_y,
   input  logic signed [COORD_WIDTH-1:0] vertex_a_z,
   input  logic signed [COORD_WIDTH-1:0] vertex_b_x,
   input  logic signed [COORD_WIDTH-1:0] vertex_b_y,
   input  logic signed [COORD_WIDTH-1:0] vertex_b_z,
   input  logic signed [COORD_WIDTH-1:0] vertex_c_x,
   input  logic signed [COORD_WIDTH-1:0] vertex_c_y,
   input  logic signed [COORD_WIDTH-1:0] vertex_c_z,
   output logic signed [COORD_WIDTH:0]   diff_vec [pit_pkg::N_DIFF][3]
);
   import pit_pkg::*;

   localparam int DW = COORD_WIDTH + 1;

   logic signed [DW-1:0] p_ext [3];
   logic signed [DW-1:0] a_ext [3];
   logic signed [DW-1:0] b_ext [3];
   logic signed [DW-1:0] c_ext [3];
   logic signed [DW-1:0] diff_in [N_DIFF][3];
   logic signed [DW-1:0] diff_ff [N_DIFF][3];

   assign p_ext[0] = DW'(point_x);
   assign p_ext[1] = DW'(point_y);
   assign p_ext[2] = DW'(point_z);
   assign a_ext[0] = DW'(vertex_a_x);
   assign a_ext[1] = DW'(vertex_a_y);
   assign a_ext[2] = DW'(vertex_a_z);
   assign b_ext[0] = DW'(vertex_b_x);
   assign b_ext[1] = DW'(vertex_b_y);
   assign b_ext[2] = DW'(vertex_b_z);
   assign c_ext[0] = DW'(vertex_c_x);
   assign c_ext[1] = DW'(vertex_c_y);
   assign c_ext[2] = DW'(vertex_c_z);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[V_CB][i] = c_ext[i] - b_ext[i];
         diff_in[V_PB][i] = p_ext[i] - b_ext[i];
         diff_in[V_AB][i] = a_ext[i] - b_ext[i];
         diff_in[V_CA][i] = c_ext[i] - a_ext[i];
         diff_in[V_PA][i] = p_ext[i] - a_ext[i];
         diff_in[V_BA][i] = b_ext[i] - a_ext[i];
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         diff_ff <= diff_in;
      end
   end

   assign diff_vec = diff_ff;

endmodule

// ===== hw/rtl/pit_cross.sv =====
// ----------------------------------------------------------------------------
// pit_cross
// Stages 2-3: cross products of the difference vectors, exact width.
// Stage 2 registers the component products, stage 3 their differences.
// ----------------------------------------------------------------------------
module pit_cross #(
   parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic [1:0]                      load_en,
   input  logic signed [COORD_WIDTH:0]     diff_vec [pit_pkg::N_DIFF][3],
   output logic signed [2*COORD_WIDTH+2:0] cross_vec [pit_pkg::N_XVEC][3]
);
   import pit_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int CW = PW + 1;

   logic signed [PW-1:0] prod_in [N_CROSS][3][2];
   logic signed [PW-1:0] prod_ff [N_CROSS][3][2];
   logic signed [DW-1:0] pa_ff [3];
   logic signed [CW-1:0] cross_in [N_XVEC][3];
   logic signed [CW-1:0] cross_ff [N_XVEC][3];

   always_comb begin
      for (int k = 0; k < N_CROSS; k++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[k][i][0] = PW'(diff_vec[CROSS_U[k]][NEXT1[i]])
                             * PW'(diff_vec[CROSS_V[k]][NEXT2[i]]);
            prod_in[k][i][1] = PW'(diff_vec[CROSS_U[k]][NEXT2[i]])
                             * PW'(diff_vec[CROSS_V[k]][NEXT1[i]]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[0]) begin
         prod_ff <= prod_in;
         pa_ff   <= diff_vec[V_PA];
      end
   end

   always_comb begin
      for (int k = 0; k < N_CROSS; k++) begin
         for (int i = 0; i < 3; i++) begin
            cross_in[k][i] = CW'(prod_ff[k][i][0]) - CW'(prod_ff[k][i][1]);
         end
      end
      // p - a rides along at the wide width for the plane distance
      for (int i = 0; i < 3; i++) begin
         cross_in[X_PA][i] = CW'(pa_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[1]) begin
         cross_ff <= cross_in;
      end
   end

   assign cross_vec = cross_ff;

endmodule

// ===== hw/rtl/pit_dot.sv =====
// ----------------------------------------------------------------------------
// pit_dot
// Stages 4-6: four exact dot products of wide vectors. Each product is split
// into two partial products on the low and high halves of one operand.
// ----------------------------------------------------------------------------
module pit_dot #(
   parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic [2:0]                      load_en,
   input  logic signed [2*COORD_WIDTH+2:0] cross_vec [pit_pkg::N_XVEC][3],
   output logic signed [4*COORD_WIDTH+7:0] dot_sum [pit_pkg::N_DOT]
);
   import pit_pkg::*;

   localparam int CW = 2 * COORD_WIDTH + 3;
   localparam int LW = (CW + 1) / 2;
   localparam int HW = CW - LW;
   localparam int FW = 2 * CW;
   localparam int SW = FW + 2;

   logic signed [CW+LW:0]   part_lo_in [N_DOT][3];
   logic signed [CW+LW:0]   part_lo_ff [N_DOT][3];
   logic signed [CW+HW-1:0] part_hi_in [N_DOT][3];
   logic signed [CW+HW-1:0] part_hi_ff [N_DOT][3];
   logic signed [FW-1:0]    prod_in [N_DOT][3];
   logic signed [FW-1:0]    prod_ff [N_DOT][3];
   logic signed [SW-1:0]    sum_in [N_DOT];
   logic signed [SW-1:0]    sum_ff [N_DOT];

   // stage 4: partial products
   always_comb begin
      for (int d = 0; d < N_DOT; d++) begin
         for (int i = 0; i < 3; i++) begin
            part_lo_in[d][i] = (CW+LW+1)'(cross_vec[DOT_U[d]][i])
                * $signed({1'b0, cross_vec[DOT_V[d]][i][LW-1:0]});
            part_hi_in[d][i] = (CW+HW)'(cross_vec[DOT_U[d]][i])
                * $signed(cross_vec[DOT_V[d]][i][CW-1:LW]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[0]) begin
         part_lo_ff <= part_lo_in;
         part_hi_ff <= part_hi_in;
      end
   end

   // stage 5: recombine the halves
   always_comb begin
      for (int d = 0; d < N_DOT; d++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[d][i] = (FW'(part_hi_ff[d][i]) <<< LW) + FW'(part_lo_ff[d][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[1]) begin
         prod_ff <= prod_in;
      end
   end

   // stage 6: sum of the three components
   always_comb begin
      for (int d = 0; d < N_DOT; d++) begin
         sum_in[d] = SW'(prod_ff[d][0]) + SW'(prod_ff[d][1]) + SW'(prod_ff[d][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[2]) begin
         sum_ff <= sum_in;
      end
   end

   assign dot_sum = sum_ff;

endmodule

// ===== hw/rtl/pit_decide.sv =====
// ----------------------------------------------------------------------------
// pit_decide
// Stage 7: same-side signs and the plane tolerance check, registered flag.
// ----------------------------------------------------------------------------
module pit_decide #(
   parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              load_en,
   input  logic signed [4*COORD_WIDTH+7:0]   dot_sum [pit_pkg::N_DOT],
   input  logic [pit_pkg::TOL_WIDTH-1:0]     plane_tolerance,
   output logic                              inside_res
);
   import pit_pkg::*;

   localparam int SW   = 4 * COORD_WIDTH + 8;
   localparam int CMPW = ((SW > TOL_WIDTH + 1) ? SW : TOL_WIDTH + 1) + 1;

   logic signed [CMPW-1:0] dist_ext;
   logic signed [CMPW-1:0] tol_ext;
   logic signed [CMPW-1:0] dist_plus_tol;
   logic                   same_side_ok;
   logic                   plane_ok;
   logic                   inside_in;
   logic                   inside_ff;

   assign dist_ext      = CMPW'(dot_sum[D_PLANE]);
   assign tol_ext       = $signed({{(CMPW-TOL_WIDTH){1'b0}}, plane_tolerance});
   assign dist_plus_tol = dist_ext + tol_ext;

   always_comb begin
      same_side_ok = 1'b1;
      for (int d = 0; d < D_PLANE; d++) begin
         same_side_ok = same_side_ok & ~dot_sum[d][SW-1];
      end
      // |t| <= tol: for negative t check t + tol >= 0
      if (dist_ext[CMPW-1]) begin
         plane_ok = ~dist_plus_tol[CMPW-1];
      end else begin
         plane_ok = (dist_ext <= tol_ext);
      end
      inside_in = same_side_ok & plane_ok;
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         inside_ff <= inside_in;
      end
   end

   assign inside_res = inside_ff;

endmodule
